// ===== hw/rtl/tftp_read_sender_macros.svh =====
// Assertion macros shared by the read sender RTL.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef TFTP_READ_SENDER_MACROS_SVH
`define TFTP_READ_SENDER_MACROS_SVH

// checked only outside reset
`define TRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/trs_pkg.sv =====
// Types, codes and constants of the TFTP read sender.
// No dependencies; used by the interfaces and all RTL modules.
`default_nettype none

package trs_pkg;

  localparam int FUNC_W  = 3;
  localparam int ACT_W   = 3;
  localparam int LEN_W   = 10;
  localparam int BLK_W   = 16;
  localparam int OPC_W   = 16;
  localparam int LIMIT_W = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd9;
  localparam logic [LEN_W-1:0]   BLOCK_BYTES = 10'd512;

  localparam logic [OPC_W-1:0] OPC_ACK   = 16'd4;
  localparam logic [OPC_W-1:0] OPC_ERROR = 16'd5;

  typedef enum logic [FUNC_W-1:0] {
    FN_START   = 3'd0,
    FN_CHUNK   = 3'd1,
    FN_REPLY   = 3'd2,
    FN_TIMEOUT = 3'd3,
    FN_FAIL    = 3'd4
  } func_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_WAIT      = 3'd0,
    ACT_NOT_FOUND = 3'd1,
    ACT_FETCH     = 3'd2,
    ACT_SEND      = 3'd3,
    ACT_COMPLETE  = 3'd4,
    ACT_ABORT     = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_FETCH = 3'b010,
    PH_WAIT  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              file_ok;
    logic [LEN_W-1:0]  chunk_length;
    logic [OPC_W-1:0]  reply_opcode;
    logic [BLK_W-1:0]  reply_block;
  } in_item_t;

  typedef struct packed {
    action_t          action;
    logic [BLK_W-1:0] out_block;
    logic [LEN_W-1:0] out_length;
  } out_item_t;

  // input register status: valid toward the core and result register, ready toward the event source
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trs_ifs.sv =====
// Channel interfaces of the TFTP read sender: events, results, configuration.
// Depends on trs_pkg.
`default_nettype none

interface trs_item_if;
  logic                      valid;
  logic                      ready;
  logic [trs_pkg::FUNC_W-1:0] func;
  logic                      file_ok;
  logic [trs_pkg::LEN_W-1:0] chunk_length;
  logic [trs_pkg::OPC_W-1:0] reply_opcode;
  logic [trs_pkg::BLK_W-1:0] reply_block;

  modport source (output valid, func, file_ok, chunk_length, reply_opcode, reply_block,
                  input ready);
  modport sink (input valid, func, file_ok, chunk_length, reply_opcode, reply_block,
                output ready);
endinterface

interface trs_result_if;
  logic                      valid;
  logic                      ready;
  logic [trs_pkg::ACT_W-1:0] action;
  logic [trs_pkg::BLK_W-1:0] out_block;
  logic [trs_pkg::LEN_W-1:0] out_length;

  modport source (output valid, action, out_block, out_length, input ready);
  modport sink (input valid, action, out_block, out_length, output ready);
endinterface

interface trs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [trs_pkg::LIMIT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tftp_read_sender.sv =====
// Path from event accept to result valid: input register, then result register.
// Throughput: one event item per cycle while rsp.ready is high; on a result stall the
// input register takes one more item, after which req.ready follows rsp.ready.
// The per-event decision is one short combinational pass inside trs_core.
// Reset (rst, synchronous, active high): session idle, block state zero,
// send_limit 9, both registers empty. Config port is always ready.
`default_nettype none

`include "tftp_read_sender_macros.svh"

module tftp_read_sender (
  input wire logic    clk,
  input wire logic    rst,
  trs_item_if.sink    req,
  trs_result_if.source rsp,
  trs_cfg_if.sink     cfg
);

  trs_pkg::in_item_t   in_item;
  trs_pkg::in_item_t   s1_item;
  trs_pkg::stage_ctl_t s1_ctl;
  trs_pkg::out_item_t  result;
  trs_pkg::out_item_t  out_item;
  logic                out_valid;
  logic                advance;
  logic                step;

  assign in_item.func         = req.func;
  assign in_item.file_ok      = req.file_ok;
  assign in_item.chunk_length = req.chunk_length;
  assign in_item.reply_opcode = req.reply_opcode;
  assign in_item.reply_block  = req.reply_block;
  assign req.ready            = s1_ctl.ready;
  assign cfg.ready            = 1'b1;

  // result register is free or being emptied this cycle
  assign advance = !out_valid || rsp.ready;
  assign step    = s1_ctl.valid && advance;

  trs_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_item  (in_item),
    .advance  (advance),
    .ctl      (s1_ctl),
    .item     (s1_item)
  );

  trs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.data),
    .step     (step),
    .item     (s1_item),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.action     = out_item.action;
  assign rsp.out_block  = out_item.out_block;
  assign rsp.out_length = out_item.out_length;

  `TRS_ASSERT(a_nonsend_zero, out_valid && out_item.action != trs_pkg::ACT_SEND |->
              out_item.out_block == '0 && out_item.out_length == '0,
              "non-data item carries block fields")
  `TRS_ASSERT(a_send_len, out_valid && out_item.action == trs_pkg::ACT_SEND |->
              out_item.out_length <= trs_pkg::BLOCK_BYTES, "data item too long")
  `TRS_ASSERT(a_step_fills_out, step |=> out_valid, "item stepped but no result")

endmodule

`default_nettype wire

// ===== hw/rtl/trs_in_reg.sv =====
// Input register of the read sender: holds one event item until the core takes it.
// Depends on trs_pkg.
`default_nettype none

`include "tftp_read_sender_macros.svh"

module trs_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire trs_pkg::in_item_t in_item,
  input  wire logic              advance,
  output trs_pkg::stage_ctl_t    ctl,
  output trs_pkg::in_item_t      item
);

  logic valid;
  logic load;

  assign ctl.ready = !valid || advance;
  assign ctl.valid = valid;
  assign load      = in_valid && ctl.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

  // a held item must not be overwritten while the core is stalled
  `TRS_ASSERT(a_hold_on_stall, valid && !advance |=> valid && $stable(item),
              "input register lost a stalled item")
  `TRS_ASSERT(a_no_ready_when_full, valid && !advance |-> !ctl.ready,
              "input register ready while full and stalled")
  `TRS_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !valid,
                     "input register valid right after reset")

endmodule

`default_nettype wire

// ===== hw/rtl/trs_core.sv =====
// Session state and per-event decision logic of the read sender.
// Depends on trs_pkg; holds the send_limit register and the session state.
`default_nettype none

`include "tftp_read_sender_macros.svh"

module trs_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [trs_pkg::LIMIT_W-1:0] cfg_data,
  input  wire logic                        step,
  input  wire trs_pkg::in_item_t           item,
  output trs_pkg::out_item_t               result
);

  logic [trs_pkg::LIMIT_W-1:0] send_limit;
  trs_pkg::phase_t             phase;
  trs_pkg::phase_t             phase_next;
  logic [trs_pkg::BLK_W-1:0]   block_number;
  logic [trs_pkg::BLK_W-1:0]   block_number_next;
  logic [trs_pkg::LEN_W-1:0]   block_length;
  logic [trs_pkg::LEN_W-1:0]   block_length_next;
  logic [trs_pkg::LIMIT_W-1:0] sends_left;
  logic [trs_pkg::LIMIT_W-1:0] sends_left_next;

  always_comb begin
    phase_next        = phase;
    block_number_next = block_number;
    block_length_next = block_length;
    sends_left_next   = sends_left;
    result.action     = trs_pkg::ACT_WAIT;
    result.out_block  = '0;
    result.out_length = '0;
    case (trs_pkg::func_t'(item.func))
      trs_pkg::FN_START: begin
        block_number_next = '0;
        block_length_next = '0;
        sends_left_next   = '0;
        if (item.file_ok) begin
          phase_next    = trs_pkg::PH_FETCH;
          result.action = trs_pkg::ACT_FETCH;
        end else begin
          phase_next    = trs_pkg::PH_IDLE;
          result.action = trs_pkg::ACT_NOT_FOUND;
        end
      end
      trs_pkg::FN_CHUNK: begin
        if (phase == trs_pkg::PH_FETCH) begin
          block_number_next = block_number + 1'b1;
          block_length_next = (item.chunk_length > trs_pkg::BLOCK_BYTES) ?
                              trs_pkg::BLOCK_BYTES : item.chunk_length;
          // a zero limit still allows the first transmission
          sends_left_next   = (send_limit == '0) ? '0 : send_limit - 1'b1;
          phase_next        = trs_pkg::PH_WAIT;
          result.action     = trs_pkg::ACT_SEND;
          result.out_block  = block_number_next;
          result.out_length = block_length_next;
        end
      end
      trs_pkg::FN_REPLY: begin
        if (phase == trs_pkg::PH_WAIT) begin
          if (item.reply_opcode == trs_pkg::OPC_ACK) begin
            if (item.reply_block == block_number) begin
              if (block_length < trs_pkg::BLOCK_BYTES) begin
                phase_next    = trs_pkg::PH_IDLE;
                result.action = trs_pkg::ACT_COMPLETE;
              end else begin
                phase_next    = trs_pkg::PH_FETCH;
                result.action = trs_pkg::ACT_FETCH;
              end
            end
          end else if (item.reply_opcode != trs_pkg::OPC_ERROR) begin
            phase_next    = trs_pkg::PH_IDLE;
            result.action = trs_pkg::ACT_ABORT;
          end
        end
      end
      trs_pkg::FN_TIMEOUT: begin
        if (phase == trs_pkg::PH_WAIT) begin
          if (sends_left != '0) begin
            sends_left_next   = sends_left - 1'b1;
            result.action     = trs_pkg::ACT_SEND;
            result.out_block  = block_number;
            result.out_length = block_length;
          end else begin
            phase_next    = trs_pkg::PH_IDLE;
            result.action = trs_pkg::ACT_ABORT;
          end
        end
      end
      trs_pkg::FN_FAIL: begin
        if (phase != trs_pkg::PH_IDLE) begin
          phase_next    = trs_pkg::PH_IDLE;
          result.action = trs_pkg::ACT_ABORT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_limit   <= trs_pkg::LIMIT_RESET;
      phase        <= trs_pkg::PH_IDLE;
      block_number <= '0;
      block_length <= '0;
      sends_left   <= '0;
    end else begin
      if (cfg_we) begin
        send_limit <= cfg_data;
      end
      if (step) begin
        phase        <= phase_next;
        block_number <= block_number_next;
        block_length <= block_length_next;
        sends_left   <= sends_left_next;
      end
    end
  end

  `TRS_ASSERT(a_send_enters_wait, step && result.action == trs_pkg::ACT_SEND |=>
              phase == trs_pkg::PH_WAIT, "data sent but not waiting for reply")
  `TRS_ASSERT(a_len_bounded, block_length <= trs_pkg::BLOCK_BYTES,
              "block length above block size")
  `TRS_ASSERT(a_idle_holds, !step |=> $stable(phase) && $stable(block_number)
              && $stable(sends_left), "session state moved without an item")

endmodule

`default_nettype wire
